### src/bcgr_pkg.sv
// Shared constants, codes and types of the buffer cache manager.
`timescale 1ns / 1ps
package bcgr_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int NUM_PROCS   = 4;
  localparam int BLOCK_BITS  = 16;
  localparam int IDX_W       = $clog2(NUM_BUFFERS);
  localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_REL     = 2'd1;
  localparam logic [1:0] ACT_REL_ALL = 2'd2;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_DELAYED = 2'd2;

  localparam logic [3:0] CODE_HIT         = 4'd0;
  localparam logic [3:0] CODE_HIT_WRITE   = 4'd1;
  localparam logic [3:0] CODE_DECLINED    = 4'd2;
  localparam logic [3:0] CODE_HELD        = 4'd3;
  localparam logic [3:0] CODE_BUSY_SLEEP  = 4'd4;
  localparam logic [3:0] CODE_MISS        = 4'd5;
  localparam logic [3:0] CODE_EMPTY_SLEEP = 4'd6;
  localparam logic [3:0] CODE_ASLEEP      = 4'd7;
  localparam logic [3:0] CODE_RELEASED    = 4'd8;
  localparam logic [3:0] CODE_NOT_HELD    = 4'd9;
  localparam logic [3:0] CODE_NONE_HELD   = 4'd10;

  typedef struct packed {
    logic [1:0]            action;
    logic [1:0]            process;
    logic [BLOCK_BITS-1:0] block;
    logic                  write_ok;
    logic                  delay_write;
  } req_t;

  typedef struct packed {
    logic                  valid;
    logic [1:0]            status;
    logic [1:0]            owner;
    logic [BLOCK_BITS-1:0] tag;
  } buf_t;

  localparam int BUF_W = $bits(buf_t);

  typedef struct packed {
    logic [3:0]            code;
    logic [IDX_W-1:0]      buffer_index;
    logic [1:0]            holder;
    logic [BLOCK_BITS-1:0] evicted_block;
    logic                  write_back;
    logic                  woken_valid;
    logic [1:0]            woken_process;
    logic                  last;
  } res_t;

endpackage

### src/bcgr_ram.sv
// Simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module bcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bcgr_ctrl.sv
// Request sequencer: scans the buffer memory, maintains the free list and process state.
`timescale 1ns / 1ps
module bcgr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bcgr_pkg::req_t in_req,
  output logic          res_valid,
  input  logic          res_ready,
  output bcgr_pkg::res_t res
);

  localparam int IW = bcgr_pkg::IDX_W;
  localparam int CW = bcgr_pkg::CNT_W;
  localparam int NP = bcgr_pkg::NUM_PROCS;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_MISS0    = 4'd4;
  localparam logic [3:0] S_MISS1    = 4'd5;
  localparam logic [3:0] S_MISS2    = 4'd6;
  localparam logic [3:0] S_FIND_RD  = 4'd7;
  localparam logic [3:0] S_FIND_CHK = 4'd8;
  localparam logic [3:0] S_SH_RD    = 4'd9;
  localparam logic [3:0] S_SH_WR    = 4'd10;
  localparam logic [3:0] S_REL      = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0]             state;
  logic [3:0]             ret_state;
  bcgr_pkg::req_t         req;
  logic [IW-1:0]          clr_cnt;
  logic [CW-1:0]          rd_cnt;
  logic                   chk_vld;
  logic [IW-1:0]          chk_idx;
  logic                   hit;
  bcgr_pkg::buf_t         hit_ent;
  logic [IW-1:0]          slot;
  logic [CW-1:0]          free_count;
  logic [CW-1:0]          fk;
  logic [CW-1:0]          rel_left;
  logic [CW-1:0]          held [NP];
  logic [NP-1:0]          asleep;
  logic [NP-1:0]          wait_emp;
  logic [bcgr_pkg::BLOCK_BITS-1:0] wait_blk [NP];

  logic                   buf_we;
  logic [IW-1:0]          buf_waddr;
  bcgr_pkg::buf_t         buf_wdata;
  logic [IW-1:0]          buf_raddr;
  logic [bcgr_pkg::BUF_W-1:0] buf_rbits;
  bcgr_pkg::buf_t         buf_rdata;
  logic                   free_we;
  logic [IW-1:0]          free_waddr;
  logic [IW-1:0]          free_wdata;
  logic [IW-1:0]          free_raddr;
  logic [IW-1:0]          free_rdata;

  logic                   lock_hit;
  logic                   wake_v;
  logic [1:0]             wake_p;
  logic [CW-1:0]          fk_inc;
  logic [CW+1:0]          held_sum;
  bcgr_pkg::res_t         idle_res;
  bcgr_pkg::res_t         rel_res;

  assign buf_rdata = bcgr_pkg::buf_t'(buf_rbits);
  assign fk_inc    = fk + 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  assign lock_hit = (req.action == bcgr_pkg::ACT_ALLOC) && hit &&
                    ((hit_ent.status == bcgr_pkg::ST_FREE) ||
                     ((hit_ent.status == bcgr_pkg::ST_DELAYED) && req.write_ok));

  // Lowest-numbered sleeper waiting for this block or for any free buffer.
  always_comb begin
    wake_v = 1'b0;
    wake_p = '0;
    for (int q = NP - 1; q >= 0; q--) begin
      if (asleep[q] && (wait_emp[q] || (wait_blk[q] == hit_ent.tag))) begin
        wake_v = 1'b1;
        wake_p = 2'(q);
      end
    end
  end

  always_comb begin
    held_sum = '0;
    for (int q = 0; q < NP; q++) begin
      held_sum = held_sum + (CW+2)'(held[q]);
    end
  end

  // Result as loaded when a request is taken; later states fill in the rest.
  always_comb begin
    idle_res      = '0;
    idle_res.last = 1'b1;
    if (in_req.action == bcgr_pkg::ACT_REL_ALL) begin
      idle_res.code = bcgr_pkg::CODE_NONE_HELD;
    end else if ((in_req.action == bcgr_pkg::ACT_ALLOC) && asleep[in_req.process]) begin
      idle_res.code = bcgr_pkg::CODE_ASLEEP;
    end
  end

  always_comb begin
    rel_res               = '0;
    rel_res.code          = bcgr_pkg::CODE_RELEASED;
    rel_res.buffer_index  = slot;
    rel_res.woken_valid   = wake_v;
    rel_res.woken_process = wake_p;
    rel_res.last          = (rel_left == CW'(1));
  end

  always_comb begin
    buf_we     = 1'b0;
    buf_waddr  = slot;
    buf_wdata  = '0;
    free_we    = 1'b0;
    free_waddr = fk[IW-1:0];
    free_wdata = free_rdata;
    buf_raddr  = (state == S_MISS1) ? free_rdata : rd_cnt[IW-1:0];
    free_raddr = (state == S_SH_RD) ? fk_inc[IW-1:0] : fk[IW-1:0];
    unique case (state)
      S_CLEAR: begin
        buf_we     = 1'b1;
        buf_waddr  = clr_cnt;
        free_we    = 1'b1;
        free_waddr = clr_cnt;
        free_wdata = clr_cnt;
      end
      S_DECIDE: begin
        buf_we           = lock_hit;
        buf_wdata.valid  = 1'b1;
        buf_wdata.status = bcgr_pkg::ST_BUSY;
        buf_wdata.owner  = req.process;
        buf_wdata.tag    = hit_ent.tag;
      end
      S_MISS2: begin
        buf_we           = 1'b1;
        buf_wdata.valid  = 1'b1;
        buf_wdata.status = bcgr_pkg::ST_BUSY;
        buf_wdata.owner  = req.process;
        buf_wdata.tag    = req.block;
      end
      S_SH_WR: begin
        free_we = 1'b1;
      end
      S_REL: begin
        buf_we           = 1'b1;
        buf_wdata        = hit_ent;
        buf_wdata.status = req.delay_write ? bcgr_pkg::ST_DELAYED : bcgr_pkg::ST_FREE;
        free_we          = 1'b1;
        free_waddr       = free_count[IW-1:0];
        free_wdata       = slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ret_state  <= S_IDLE;
      clr_cnt    <= '0;
      free_count <= CW'(bcgr_pkg::NUM_BUFFERS);
      chk_vld    <= 1'b0;
      asleep     <= '0;
      wait_emp   <= '0;
      for (int q = 0; q < NP; q++) begin
        held[q]     <= '0;
        wait_blk[q] <= '0;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IW'(bcgr_pkg::NUM_BUFFERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req       <= in_req;
            rd_cnt    <= '0;
            chk_vld   <= 1'b0;
            hit       <= 1'b0;
            ret_state <= S_IDLE;
            res       <= idle_res;
            priority if (in_req.action == bcgr_pkg::ACT_ALLOC) begin
              if (asleep[in_req.process]) begin
                state <= S_EMIT;
              end else begin
                state <= S_SCAN;
              end
            end else if (in_req.action == bcgr_pkg::ACT_REL) begin
              state <= S_SCAN;
            end else if (in_req.action == bcgr_pkg::ACT_REL_ALL) begin
              rel_left <= held[in_req.process];
              if (held[in_req.process] == '0) begin
                state <= S_EMIT;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          // Reads are pipelined: the entry read last cycle is checked now.
          if (chk_vld && (req.action == bcgr_pkg::ACT_REL_ALL) &&
              (buf_rdata.status == bcgr_pkg::ST_BUSY) &&
              (buf_rdata.owner == req.process)) begin
            slot    <= chk_idx;
            hit_ent <= buf_rdata;
            chk_vld <= 1'b0;
            state   <= S_REL;
          end else if (chk_vld && (req.action != bcgr_pkg::ACT_REL_ALL) &&
                       buf_rdata.valid && (buf_rdata.tag == req.block)) begin
            hit     <= 1'b1;
            slot    <= chk_idx;
            hit_ent <= buf_rdata;
            chk_vld <= 1'b0;
            state   <= S_DECIDE;
          end else if (rd_cnt < CW'(bcgr_pkg::NUM_BUFFERS)) begin
            chk_vld <= 1'b1;
            chk_idx <= rd_cnt[IW-1:0];
            rd_cnt  <= rd_cnt + 1'b1;
          end else begin
            chk_vld <= 1'b0;
            if (!chk_vld) begin
              state <= (req.action == bcgr_pkg::ACT_REL_ALL) ? S_IDLE : S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (req.action == bcgr_pkg::ACT_REL) begin
            if (hit && (hit_ent.status == bcgr_pkg::ST_BUSY) &&
                (hit_ent.owner == req.process)) begin
              rel_left <= CW'(1);
              state    <= S_REL;
            end else begin
              res.code <= bcgr_pkg::CODE_NOT_HELD;
              state    <= S_EMIT;
            end
          end else if (hit) begin
            res.buffer_index <= slot;
            priority if (lock_hit) begin
              res.code <= (hit_ent.status == bcgr_pkg::ST_FREE) ?
                          bcgr_pkg::CODE_HIT : bcgr_pkg::CODE_HIT_WRITE;
              held[req.process] <= held[req.process] + 1'b1;
              fk    <= '0;
              state <= S_FIND_RD;
            end else if (hit_ent.status == bcgr_pkg::ST_DELAYED) begin
              res.code <= bcgr_pkg::CODE_DECLINED;
              state    <= S_EMIT;
            end else if (hit_ent.owner == req.process) begin
              res.code   <= bcgr_pkg::CODE_HELD;
              res.holder <= req.process;
              state      <= S_EMIT;
            end else begin
              res.code                <= bcgr_pkg::CODE_BUSY_SLEEP;
              res.holder              <= hit_ent.owner;
              asleep[req.process]     <= 1'b1;
              wait_emp[req.process]   <= 1'b0;
              wait_blk[req.process]   <= req.block;
              state                   <= S_EMIT;
            end
          end else if (free_count == '0) begin
            res.code                <= bcgr_pkg::CODE_EMPTY_SLEEP;
            asleep[req.process]     <= 1'b1;
            wait_emp[req.process]   <= 1'b1;
            wait_blk[req.process]   <= req.block;
            state                   <= S_EMIT;
          end else begin
            fk    <= '0;
            state <= S_MISS0;
          end
        end
        S_MISS0: begin
          state <= S_MISS1;
        end
        S_MISS1: begin
          slot  <= free_rdata;
          state <= S_MISS2;
        end
        S_MISS2: begin
          res.code          <= bcgr_pkg::CODE_MISS;
          res.buffer_index  <= slot;
          res.evicted_block <= buf_rdata.tag;
          res.write_back    <= (buf_rdata.status == bcgr_pkg::ST_DELAYED);
          held[req.process] <= held[req.process] + 1'b1;
          fk                <= '0;
          state             <= S_SH_RD;
        end
        S_FIND_RD: begin
          state <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (free_rdata == slot) begin
            state <= S_SH_RD;
          end else begin
            fk    <= fk_inc;
            state <= S_FIND_RD;
          end
        end
        S_SH_RD: begin
          if (fk_inc < free_count) begin
            state <= S_SH_WR;
          end else begin
            free_count <= free_count - 1'b1;
            state      <= S_EMIT;
          end
        end
        S_SH_WR: begin
          fk    <= fk_inc;
          state <= S_SH_RD;
        end
        S_REL: begin
          free_count        <= free_count + 1'b1;
          held[req.process] <= held[req.process] - 1'b1;
          if (wake_v) begin
            asleep[wake_p]   <= 1'b0;
            wait_emp[wake_p] <= 1'b0;
          end
          res               <= rel_res;
          rel_left          <= rel_left - 1'b1;
          ret_state         <= (rel_left == CW'(1)) ? S_IDLE : S_SCAN;
          rd_cnt            <= CW'(slot) + 1'b1;
          chk_vld           <= 1'b0;
          state             <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= ret_state;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bcgr_ram #(.WIDTH(bcgr_pkg::BUF_W), .DEPTH(bcgr_pkg::NUM_BUFFERS)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rbits)
  );

  bcgr_ram #(.WIDTH(IW), .DEPTH(bcgr_pkg::NUM_BUFFERS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(bcgr_pkg::NUM_BUFFERS))
    else $error("free list count exceeds buffer count");

  a_conserve: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (held_sum + (CW+2)'(free_count) == (CW+2)'(bcgr_pkg::NUM_BUFFERS)))
    else $error("held buffers and free list disagree");

  a_rel_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_REL) |-> (hit_ent.status == bcgr_pkg::ST_BUSY))
    else $error("release of a buffer that is not busy");

  a_find_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND_CHK) |-> (fk < free_count))
    else $error("free list search ran past its end");

endmodule

### src/buffer_cache_getblk_release_core.sv
// Top level of the buffer cache manager: request sequencer plus output register.
`timescale 1ns / 1ps
// Buffer cache manager for sixteen tagged buffers. One request is handled at a
// time; the next one is taken once the current one has handed its last result to
// the output register. Each request, but an allocate by a sleeping process or a
// release-all by a process that holds nothing, walks the buffer memory one entry
// per cycle, since tags, state and owner live in a one-port-read memory.
// An allocate that locks a buffer also unlinks it from the free list held in a
// second memory: on a hit it searches the list entry by entry for the buffer, and
// it then shifts each later list entry down one place. A release-all rescans from
// the slot after each buffer it frees. After reset a pass over every entry
// initializes both memories before the first request.
module buffer_cache_getblk_release_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // process[1:0], block[17:2], write_ok[18], delay_write[19]
  input  logic [1:0]  s_tuser,  // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // buffer_index[3:0], holder[5:4], evicted_block[21:6],
                                // write_back[22], woken_valid[23], woken_process[25:24]
  output logic [3:0]  m_tuser,  // code[3:0]
  output logic        m_tlast
);

  bcgr_pkg::req_t in_req;
  bcgr_pkg::res_t res;
  bcgr_pkg::res_t out_res;
  logic           res_valid;
  logic           res_ready;
  logic           out_full;

  assign in_req.action      = s_tuser;
  assign in_req.process     = s_tdata[1:0];
  assign in_req.block       = s_tdata[17:2];
  assign in_req.write_ok    = s_tdata[18];
  assign in_req.delay_write = s_tdata[19];

  bcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_full || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_full;
  assign m_tuser  = out_res.code;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {6'd0, out_res.woken_process, out_res.woken_valid, out_res.write_back,
                     out_res.evicted_block, out_res.holder, out_res.buffer_index};

endmodule

### dv/tb_buffer_cache_getblk_release_core.sv
// Self-checking testbench of the buffer cache manager with its own state predictor.
`timescale 1ns / 1ps
module tb_buffer_cache_getblk_release_core;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  action;
    logic [1:0]  process;
    logic [15:0] block;
    logic        write_ok;
    logic        delay_write;
  } request_t;

  typedef struct {
    logic [3:0]  code;
    logic [3:0]  index;
    logic [1:0]  holder;
    logic [15:0] evicted;
    logic        write_back;
    logic        woken_valid;
    logic [1:0]  woken;
    logic        last;
  } outcome_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic [3:0] m_tuser;
  logic m_tlast;

  buffer_cache_getblk_release_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predicted cache state.
  logic [15:0] tag_q [bcgr_pkg::NUM_BUFFERS];
  logic        valid_q [bcgr_pkg::NUM_BUFFERS];
  logic [1:0]  status_q [bcgr_pkg::NUM_BUFFERS];
  logic [1:0]  owner_q [bcgr_pkg::NUM_BUFFERS];
  int          lru_q [$];
  logic        asleep_q [bcgr_pkg::NUM_PROCS];
  logic [15:0] wait_blk_q [bcgr_pkg::NUM_PROCS];
  logic        wait_empty_q [bcgr_pkg::NUM_PROCS];

  request_t pending_reqs [$];
  outcome_t expected_results [$];
  int errors = 0;
  int send_idle = 23;
  int recv_idle = 75;
  bit hold_recv = 0;
  bit pause_send = 0;
  longint cycles = 0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic void push_result(input logic [3:0] code, input int idx, input int hold,
                                      input logic [15:0] ev, input bit wb, input bit wv,
                                      input int wp);
    outcome_t o;
    o.code = code; o.index = 4'(idx); o.holder = 2'(hold); o.evicted = ev;
    o.write_back = wb; o.woken_valid = wv; o.woken = 2'(wp); o.last = 0;
    expected_results.push_back(o);
  endfunction

  function automatic void lock_buffer(input int s, input int p);
    status_q[s] = bcgr_pkg::ST_BUSY;
    owner_q[s] = 2'(p);
    foreach (lru_q[k]) if (lru_q[k] == s) begin
      lru_q.delete(k);
      break;
    end
  endfunction

  function automatic void free_buffer(input int s, input bit dly);
    bit wv = 0;
    int wp = 0;
    status_q[s] = dly ? bcgr_pkg::ST_DELAYED : bcgr_pkg::ST_FREE;
    lru_q.push_back(s);
    for (int q = 0; q < bcgr_pkg::NUM_PROCS; q++)
      if (asleep_q[q] && (wait_empty_q[q] || wait_blk_q[q] == tag_q[s])) begin
        asleep_q[q] = 0;
        wait_empty_q[q] = 0;
        wv = 1;
        wp = q;
        break;
      end
    push_result(bcgr_pkg::CODE_RELEASED, s, 0, 0, 0, wv, wp);
  endfunction

  function automatic void predict_request(input request_t r);
    int hit = -1;
    int n = 0;
    int p = r.process;
    int s;
    int start_size = expected_results.size();
    for (int k = 0; k < bcgr_pkg::NUM_BUFFERS; k++)
      if (valid_q[k] && tag_q[k] == r.block) begin
        hit = k;
        break;
      end
    if (r.action == bcgr_pkg::ACT_ALLOC) begin
      if (asleep_q[p]) push_result(bcgr_pkg::CODE_ASLEEP, 0, 0, 0, 0, 0, 0);
      else if (hit >= 0) begin
        if (status_q[hit] == bcgr_pkg::ST_FREE) begin
          lock_buffer(hit, p);
          push_result(bcgr_pkg::CODE_HIT, hit, 0, 0, 0, 0, 0);
        end else if (status_q[hit] == bcgr_pkg::ST_DELAYED) begin
          if (r.write_ok) begin
            lock_buffer(hit, p);
            push_result(bcgr_pkg::CODE_HIT_WRITE, hit, 0, 0, 0, 0, 0);
          end else push_result(bcgr_pkg::CODE_DECLINED, hit, 0, 0, 0, 0, 0);
        end else if (owner_q[hit] == p) push_result(bcgr_pkg::CODE_HELD, hit, p, 0, 0, 0, 0);
        else begin
          asleep_q[p] = 1; wait_blk_q[p] = r.block; wait_empty_q[p] = 0;
          push_result(bcgr_pkg::CODE_BUSY_SLEEP, hit, owner_q[hit], 0, 0, 0, 0);
        end
      end else if (lru_q.size() == 0) begin
        asleep_q[p] = 1; wait_blk_q[p] = r.block; wait_empty_q[p] = 1;
        push_result(bcgr_pkg::CODE_EMPTY_SLEEP, 0, 0, 0, 0, 0, 0);
      end else begin
        s = lru_q[0];
        push_result(bcgr_pkg::CODE_MISS, s, 0, tag_q[s],
                    status_q[s] == bcgr_pkg::ST_DELAYED, 0, 0);
        tag_q[s] = r.block;
        valid_q[s] = 1;
        lock_buffer(s, p);
      end
    end else if (r.action == bcgr_pkg::ACT_REL) begin
      if (hit >= 0 && status_q[hit] == bcgr_pkg::ST_BUSY && owner_q[hit] == p)
        free_buffer(hit, r.delay_write);
      else push_result(bcgr_pkg::CODE_NOT_HELD, 0, 0, 0, 0, 0, 0);
    end else if (r.action == bcgr_pkg::ACT_REL_ALL) begin
      for (int k = 0; k < bcgr_pkg::NUM_BUFFERS; k++)
        if (status_q[k] == bcgr_pkg::ST_BUSY && owner_q[k] == p) begin
          free_buffer(k, r.delay_write);
          n++;
        end
      if (n == 0) push_result(bcgr_pkg::CODE_NONE_HELD, 0, 0, 0, 0, 0, 0);
    end
    if (expected_results.size() > start_size)
      expected_results[expected_results.size() - 1].last = 1;
  endfunction

  // Driver: a transfer happens at the edge, the predictor runs on acceptance.
  always @(posedge clk) begin
    request_t r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_request(pending_reqs.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_reqs.size() > 0 && !pause_send && $urandom_range(99) >= send_idle) begin
          r = pending_reqs[0];
          s_tvalid <= 1;
          s_tuser <= r.action;
          s_tdata <= {4'b0, r.delay_write, r.write_ok, r.block, r.process};
        end else s_tvalid <= 0;
      end
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    outcome_t e;
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) report($sformatf("unexpected result %h", m_tdata));
        else begin
          e = expected_results.pop_front();
          if (m_tuser !== e.code) report($sformatf("code %0d exp %0d", m_tuser, e.code));
          if (m_tdata[3:0] !== e.index) report($sformatf("index %0d exp %0d",
                                                         m_tdata[3:0], e.index));
          if (m_tdata[5:4] !== e.holder) report("holder differs");
          if (m_tdata[21:6] !== e.evicted) report($sformatf("evicted %h exp %h",
                                                            m_tdata[21:6], e.evicted));
          if (m_tdata[22] !== e.write_back) report("write_back differs");
          if (m_tdata[23] !== e.woken_valid) report("woken_valid differs");
          if (m_tdata[25:24] !== e.woken) report("woken_process differs");
          if (m_tdata[31:26] !== 6'b0) report("padding bits set");
          if (m_tlast !== e.last) report("last differs");
        end
      end
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end
    if (cycles > 600000) begin
      $display("tb_buffer_cache_getblk_release_core NOT OK");
      $finish;
    end
  end

  function automatic request_t make_req(input int act, input int p, input int blk,
                                        input bit wok, input bit dly);
    request_t r;
    r.action = 2'(act); r.process = 2'(p); r.block = 16'(blk);
    r.write_ok = wok; r.delay_write = dly;
    return r;
  endfunction

  // Random request over a small block set so hits, busy hits and sleeps are common.
  function automatic request_t random_req();
    int a = $urandom_range(99);
    int blk = ($urandom_range(9) == 0) ? $urandom : $urandom_range(23) * 16'h0a51;
    int act = (a < 55) ? bcgr_pkg::ACT_ALLOC : (a < 88) ? bcgr_pkg::ACT_REL :
              (a < 97) ? bcgr_pkg::ACT_REL_ALL : ACT_UNUSED;
    return make_req(act, $urandom_range(3), blk, $urandom_range(1), $urandom_range(1));
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < bcgr_pkg::NUM_BUFFERS; k++) begin
      tag_q[k] = 0; valid_q[k] = 0; status_q[k] = bcgr_pkg::ST_FREE; owner_q[k] = 0;
      lru_q.push_back(k);
    end
    for (int q = 0; q < bcgr_pkg::NUM_PROCS; q++) begin
      asleep_q[q] = 0; wait_blk_q[q] = 0; wait_empty_q[q] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 0;
    // Directed: never-used slot miss of block zero, extremes, every code but a plain hit.
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_REL_ALL, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 0, 16'hffff, 1, 1));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_REL, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 1, 5, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_REL, 0, 0, 0, 1));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 2, 0, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 2, 0, 1, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_REL, 2, 0, 1, 0));
    pending_reqs.push_back(make_req(ACT_UNUSED, 3, 16'haaaa, 1, 1));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_REL_ALL, 0, 0, 0, 1));
    for (int k = 0; k < 16; k++)
      pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 3, 100 + k, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 1, 16'h5555, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_ALLOC, 0, 16'h5555, 0, 0));
    pending_reqs.push_back(make_req(bcgr_pkg::ACT_REL_ALL, 3, 0, 0, 0));
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 23 : (phase == 1) ? 75 : 0;
      recv_idle = (phase == 0) ? 75 : (phase == 1) ? 23 : 0;
      for (int k = 0; k < 90; k++) pending_reqs.push_back(random_req());
      if (phase == 2) begin
        hold_recv = 1;
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
      drain();
      // Sender pauses here with nothing outstanding before the next phase.
      pause_send = 1;
      repeat (20) @(posedge clk);
      pause_send = 0;
    end
    if (errors == 0) $display("tb_buffer_cache_getblk_release_core OK");
    else $display("tb_buffer_cache_getblk_release_core NOT OK");
    $finish;
  end
endmodule

### sim.f
src/bcgr_pkg.sv
src/bcgr_ram.sv
src/bcgr_ctrl.sv
src/buffer_cache_getblk_release_core.sv
dv/tb_buffer_cache_getblk_release_core.sv
